// ===== rtl/gbfs_pkg.sv =====
// gbfs_pkg: sizes, codes and shared types of the grid BFS shortest path core.
// Used by gbfs_nbr_unit and grid_bfs_shortest_path_core; depends on nothing.

package gbfs_pkg;

   // grid limits
   localparam int unsigned MAX_ROWS   = 128;
   localparam int unsigned MAX_COLS   = 128;
   localparam int unsigned CELL_COUNT = MAX_ROWS * MAX_COLS;

   localparam int unsigned ROW_W  = $clog2(MAX_ROWS);       // row coordinate
   localparam int unsigned COL_W  = $clog2(MAX_COLS);       // column coordinate
   localparam int unsigned ROWS_W = $clog2(MAX_ROWS + 1);   // row count 1..MAX_ROWS
   localparam int unsigned COLS_W = $clog2(MAX_COLS + 1);   // column count 1..MAX_COLS
   localparam int unsigned CELL_W = $clog2(CELL_COUNT);     // raster cell index
   localparam int unsigned PTR_W  = $clog2(CELL_COUNT + 1); // queue pointers

   // path length in cells, saturating
   localparam int unsigned LEN_W = 15;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // control registers
   localparam int unsigned CSR_W     = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = CSR_IDX_W'(1);

   // neighbor visiting order
   typedef enum logic [1:0] {
      DIR_UP,
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT
   } dir_type;

   // one queue entry
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] idx;
      logic [LEN_W-1:0]  len;
   } entry_type;

   // neighbor of the current cell
   typedef struct packed {
      logic              ok;   // inside the grid
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] idx;
   } nbr_type;

   // 0 acts as 1, above the limit acts as the limit
   function automatic int unsigned clamp_dim(input logic [CSR_W-1:0] v,
                                             input int unsigned maxv);
      int unsigned r;
      r = int'(v);
      if (r == 0) begin
         r = 1;
      end else if (r > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

// ===== rtl/gbfs_nbr_unit.sv =====
// gbfs_nbr_unit: neighbor address and bounds check for one direction.
// One shared adder forms the raster index; depends on gbfs_pkg.

module gbfs_nbr_unit (
   input  gbfs_pkg::entry_type               cur,
   input  gbfs_pkg::dir_type                 dir,
   input  logic [gbfs_pkg::ROWS_W-1:0]       rows,
   input  logic [gbfs_pkg::COLS_W-1:0]       cols,
   output gbfs_pkg::nbr_type                 nbr
);
   import gbfs_pkg::*;

   logic [CELL_W-1:0] addend;
   logic [CELL_W-1:0] cols_ext;

   assign cols_ext = CELL_W'(cols);

   always_comb begin
      nbr.ok  = 1'b0;
      nbr.row = cur.row;
      nbr.col = cur.col;
      addend  = '0;
      case (dir)
         DIR_UP: begin
            nbr.ok  = cur.row != '0;
            nbr.row = cur.row - ROW_W'(1);
            addend  = '0 - cols_ext;
         end
         DIR_RIGHT: begin
            nbr.ok  = (COLS_W'(cur.col) + COLS_W'(1)) != cols;
            nbr.col = cur.col + COL_W'(1);
            addend  = CELL_W'(1);
         end
         DIR_DOWN: begin
            nbr.ok  = (ROWS_W'(cur.row) + ROWS_W'(1)) != rows;
            nbr.row = cur.row + ROW_W'(1);
            addend  = cols_ext;
         end
         DIR_LEFT: begin
            nbr.ok  = cur.col != '0;
            nbr.col = cur.col - COL_W'(1);
            addend  = {CELL_W{1'b1}};
         end
         default: begin
            nbr.ok = 1'b0;
         end
      endcase
      // single shared adder, wraps mod 2^CELL_W
      nbr.idx = cur.idx + addend;
   end

endmodule

// ===== rtl/grid_bfs_shortest_path_core.sv =====
// grid_bfs_shortest_path_core: maze loader, BFS sequencer and result register.
// Depends on gbfs_pkg and gbfs_nbr_unit.
// Throughput: one cell word per cycle while loading; after the last cell the
//   input stalls until the search has finished and its result word is issued.
// Reset: 1x1 grid, load position and queue cleared, no result pending.

module grid_bfs_shortest_path_core (
   input  logic                               clock,
   input  logic                               reset,
   // cell words, raster order
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cell_open,
   // result words
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gbfs_pkg::LEN_W-1:0]         rsp_path_length,
   output logic                               rsp_reachable,
   // register writes
   input  logic                               csr_we,
   input  logic [gbfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbfs_pkg::CSR_W-1:0]         csr_wdata
);
   import gbfs_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_INIT,
      S_POP,
      S_ENTRY,
      S_NB_ADDR,
      S_NB_TEST,
      S_DONE
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [ROWS_W-1:0]  rows_ff, rows_in;       // clamped on write
   logic [COLS_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]   load_row_ff, load_row_in;
   logic [COL_W-1:0]   load_col_ff, load_col_in;
   logic [CELL_W-1:0]  load_idx_ff, load_idx_in;
   logic [CELL_W-1:0]  target_ff, target_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   dir_type            dir_ff, dir_in;
   nbr_type            nbr_ff, nbr_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   // memories
   logic               vis_mem [CELL_COUNT];
   logic               vis_we;
   logic [CELL_W-1:0]  vis_waddr;
   logic               vis_wdata;
   logic               vis_re;
   logic               vis_rd_ff;

   entry_type          fifo_mem [CELL_COUNT];
   logic               fifo_we;
   entry_type          fifo_wdata;
   logic [CELL_W-1:0]  fifo_waddr;
   logic               fifo_re;
   entry_type          fifo_rd_ff;              // current cell while expanding

   nbr_type            nbr;
   logic               accept;
   logic               load_last;
   logic [LEN_W-1:0]   dist_next;

   // shared neighbor adder
   gbfs_nbr_unit u_nbr (
      .cur  (fifo_rd_ff),
      .dir  (dir_ff),
      .rows (rows_ff),
      .cols (cols_ff),
      .nbr  (nbr)
   );

   assign req_stall = state_ff != S_LOAD;
   assign accept    = req_valid && !req_stall;
   assign load_last = (load_row_ff == ROW_W'(rows_ff - ROWS_W'(1))) &&
                      (load_col_ff == COL_W'(cols_ff - COLS_W'(1)));
   assign dist_next = (fifo_rd_ff.len == LEN_MAX) ? fifo_rd_ff.len
                                                  : fifo_rd_ff.len + LEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      load_row_in  = load_row_ff;
      load_col_in  = load_col_ff;
      load_idx_in  = load_idx_ff;
      target_in    = target_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      dir_in       = dir_ff;
      nbr_in       = nbr_ff;
      res_len_in   = res_len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;

      vis_we     = 1'b0;
      vis_waddr  = load_idx_ff;
      vis_wdata  = 1'b1;
      vis_re     = 1'b0;
      fifo_we    = 1'b0;
      fifo_waddr = tail_ff[CELL_W-1:0];
      fifo_wdata = '{row: nbr_ff.row, col: nbr_ff.col, idx: nbr_ff.idx, len: dist_next};
      fifo_re    = 1'b0;

      // result word leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               // walls go in as already visited
               vis_we    = 1'b1;
               vis_waddr = load_idx_ff;
               vis_wdata = !req_cell_open;
               if (load_last) begin
                  target_in   = load_idx_ff;
                  load_row_in = '0;
                  load_col_in = '0;
                  load_idx_in = '0;
                  state_in    = S_INIT;
               end else begin
                  load_idx_in = load_idx_ff + CELL_W'(1);
                  if (load_col_ff == COL_W'(cols_ff - COLS_W'(1))) begin
                     load_col_in = '0;
                     load_row_in = load_row_ff + ROW_W'(1);
                  end else begin
                     load_col_in = load_col_ff + COL_W'(1);
                  end
               end
            end
         end
         S_INIT: begin
            // start cell is always open and enters with distance 1
            vis_we     = 1'b1;
            vis_waddr  = '0;
            vis_wdata  = 1'b1;
            fifo_we    = 1'b1;
            fifo_waddr = '0;
            fifo_wdata = '{row: '0, col: '0, idx: '0, len: LEN_W'(1)};
            head_in    = '0;
            tail_in    = PTR_W'(1);
            state_in   = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               res_len_in = '0;            // queue drained, target not reached
               state_in   = S_DONE;
            end else begin
               fifo_re  = 1'b1;
               head_in  = head_ff + PTR_W'(1);
               state_in = S_ENTRY;
            end
         end
         S_ENTRY: begin
            if (fifo_rd_ff.idx == target_ff) begin
               res_len_in = fifo_rd_ff.len;
               state_in   = S_DONE;
            end else begin
               dir_in   = DIR_UP;
               state_in = S_NB_ADDR;
            end
         end
         S_NB_ADDR: begin
            if (nbr.ok) begin
               vis_re   = 1'b1;
               nbr_in   = nbr;
               state_in = S_NB_TEST;
            end else if (dir_ff == DIR_LEFT) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_type'(dir_ff + 2'd1);
            end
         end
         S_NB_TEST: begin
            if (!vis_rd_ff) begin
               vis_we    = 1'b1;
               vis_waddr = nbr_ff.idx;
               vis_wdata = 1'b1;
               if (tail_ff < PTR_W'(CELL_COUNT)) begin
                  fifo_we = 1'b1;
                  tail_in = tail_ff + PTR_W'(1);
               end
            end
            if (dir_ff == DIR_LEFT) begin
               state_in = S_POP;
            end else begin
               dir_in   = dir_type'(dir_ff + 2'd1);
               state_in = S_NB_ADDR;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = res_len_ff;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // a size write restarts the maze
      if (csr_we) begin
         case (csr_index)
            REG_GRID_ROWS: begin
               rows_in     = ROWS_W'(clamp_dim(csr_wdata, MAX_ROWS));
               load_row_in = '0;
               load_col_in = '0;
               load_idx_in = '0;
            end
            REG_GRID_COLS: begin
               cols_in     = COLS_W'(clamp_dim(csr_wdata, MAX_COLS));
               load_row_in = '0;
               load_col_in = '0;
               load_idx_in = '0;
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rows_ff      <= ROWS_W'(1);
         cols_ff      <= COLS_W'(1);
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         load_idx_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         dir_ff       <= DIR_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         load_idx_ff  <= load_idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff  <= target_in;
      nbr_ff     <= nbr_in;
      res_len_ff <= res_len_in;
      rsp_len_ff <= rsp_len_in;
   end

   // visited map: one write, one registered read
   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_waddr] <= vis_wdata;
      end
      if (vis_re) begin
         vis_rd_ff <= vis_mem[nbr.idx];
      end
   end

   // search queue: one write, one registered read
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
      if (fifo_re) begin
         fifo_rd_ff <= fifo_mem[head_ff[CELL_W-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_reachable   = rsp_len_ff != '0;

   // queue never underflows
   assert property (@(posedge clock) disable iff (reset) head_ff <= tail_ff)
      else $error("search queue head passed tail");

   // a result word only appears at the end of a search
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word without a finished search");

   // a new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(rsp_len_ff) && rsp_valid_ff))
      else $error("pending result word lost");

endmodule

// ===== bench/grid_bfs_shortest_path_core_test.sv =====
// Self-checking bench for grid_bfs_shortest_path_core: feeds mazes cell by cell,
// predicts each path length with a breadth-first search of its own and checks results.
// Depends on gbfs_pkg and the core RTL.
`timescale 1ns / 1ps

module grid_bfs_shortest_path_core_test;
   import gbfs_pkg::*;

   localparam int SETTLE_CYCLES = 16;   // a stray cell word may still be landing
   localparam int TAIL_CYCLES   = 64;   // watch for extra result words at the end
   localparam int SNAKE_COLS    = 4;    // width of the full-height serpentine

   typedef struct packed {
      logic [LEN_W-1:0] path_length;
      logic             reachable;
   } maze_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cell_open = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [LEN_W-1:0]     rsp_path_length;
   logic                 rsp_reachable;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_GRID_ROWS;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // bench-side copy of the block's state
   logic [CSR_W-1:0] grid_rows_raw = CSR_W'(1);
   logic [CSR_W-1:0] grid_cols_raw = CSR_W'(1);
   int               load_pos = 0;
   bit               cell_blocked [CELL_COUNT];   // walls, as loaded into the visited map
   bit               bfs_seen [CELL_COUNT];
   bit               maze_plan [CELL_COUNT];      // maze about to be sent

   maze_answer_type answers_due [$];
   int              mismatch_count = 0;
   int              req_idle_pct = 0;
   int              rsp_stall_pct = 0;

   grid_bfs_shortest_path_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cell_open   (req_cell_open),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_path_length (rsp_path_length),
      .rsp_reachable   (rsp_reachable),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Size in use: 0 acts as 1, anything over the limit acts as the limit.
   function automatic int dim_in_use(input logic [CSR_W-1:0] raw, input int limit);
      if (raw == 0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   // Cells on the shortest path from top-left to bottom-right, 0 if there is none.
   // The start cell counts as open whatever was loaded for it.
   function automatic int shortest_path_cells(input int rows, input int cols);
      int frontier [$];
      int depth [$];
      int here, here_len, r, c, nr, nc, k, nidx, i;
      for (i = 0; i < rows * cols; i++) bfs_seen[i] = cell_blocked[i];
      bfs_seen[0] = 1'b1;
      frontier.push_back(0);
      depth.push_back(1);
      while (frontier.size() > 0) begin
         here = frontier.pop_front();
         here_len = depth.pop_front();
         if (here == rows * cols - 1) return here_len;
         r = here / cols;
         c = here % cols;
         for (k = 0; k < 4; k++) begin
            nr = r;
            nc = c;
            case (dir_type'(k))
               DIR_UP:    nr = r - 1;
               DIR_RIGHT: nc = c + 1;
               DIR_DOWN:  nr = r + 1;
               default:   nc = c - 1;
            endcase
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            nidx = nr * cols + nc;
            if (bfs_seen[nidx]) continue;
            bfs_seen[nidx] = 1'b1;
            frontier.push_back(nidx);
            depth.push_back(here_len + 1);
         end
      end
      return 0;
   endfunction

   // One accepted cell word; the last cell of a maze yields one expected result.
   task automatic predict_cell(input logic open);
      int total, len;
      maze_answer_type due;
      total = dim_in_use(grid_rows_raw, MAX_ROWS) * dim_in_use(grid_cols_raw, MAX_COLS);
      if (load_pos >= total) load_pos = 0;
      cell_blocked[load_pos] = !open;
      load_pos++;
      if (load_pos == total) begin
         load_pos = 0;
         len = shortest_path_cells(dim_in_use(grid_rows_raw, MAX_ROWS),
                                   dim_in_use(grid_cols_raw, MAX_COLS));
         due.path_length = (len > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(len);
         due.reachable   = (len != 0);
         answers_due.push_back(due);
      end
   endtask

   // Send one cell word; sender idles at random before raising valid.
   task automatic send_cell_word(input logic open);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_open <= open;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cell(open);
   endtask

   task automatic send_pattern(input logic [15:0] cells, input int count);
      int i;
      for (i = 0; i < count; i++) send_cell_word(cells[i]);
   endtask

   task automatic send_plan(input int count);
      int i;
      for (i = 0; i < count; i++) send_cell_word(maze_plan[i]);
   endtask

   // Sender holds off until every outstanding result word is back, then waits
   // out the settle time so the core is fully idle.
   task automatic drain_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Caller guarantees the core is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == REG_GRID_ROWS) grid_rows_raw = value;
      else if (index == REG_GRID_COLS) grid_cols_raw = value;
      load_pos = 0;
   endtask

   task automatic set_grid(input logic [CSR_W-1:0] rows_v, input logic [CSR_W-1:0] cols_v);
      drain_answers();
      write_reg(REG_GRID_ROWS, rows_v);
      write_reg(REG_GRID_COLS, cols_v);
   endtask

   // Result checker: every accepted result word against the oldest prediction.
   always @(posedge clock) begin
      maze_answer_type due;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            $error("result word with nothing expected: path_length %0d reachable %0b",
                   rsp_path_length, rsp_reachable);
            mismatch_count++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_path_length !== due.path_length) begin
               $error("path_length: expected %0d, got %0d", due.path_length, rsp_path_length);
               mismatch_count++;
            end
            if (rsp_reachable !== due.reachable) begin
               $error("reachable: expected %0b, got %0b", due.reachable, rsp_reachable);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // 1x1 from reset, then 1x1 again through zero sizes; a lone cell is
   // always a path of one, even when loaded as a wall.
   task automatic test_single_cell();
      send_cell_word(1'b1);
      set_grid(CSR_W'(0), CSR_W'(0));
      send_cell_word(1'b0);
   endtask

   // 2x2: wall on the start, wall on the target, target cut off.
   task automatic test_corner_walls();
      set_grid(CSR_W'(2), CSR_W'(2));
      send_pattern(16'b1110, 4);
      send_pattern(16'b0111, 4);
      send_pattern(16'b1001, 4);
   endtask

   // A register write throws away a half-loaded maze.
   task automatic test_reload_after_write();
      set_grid(CSR_W'(2), CSR_W'(3));
      send_pattern(16'b0000, 4);
      drain_answers();
      write_reg(REG_GRID_COLS, CSR_W'(3));
      send_pattern(16'b111111, 6);
   endtask

   // Single row and single column at the size limit, via oversize values.
   task automatic test_clamped_strips();
      int i;
      for (i = 0; i < int'(MAX_ROWS); i++) maze_plan[i] = 1'b1;
      set_grid(CSR_W'(255), CSR_W'(1));
      send_plan(MAX_ROWS);
      set_grid(CSR_W'(1), CSR_W'(MAX_COLS + 1));
      send_plan(MAX_COLS);
   endtask

   // Full-height serpentine: even rows open, odd rows walls with one gap that
   // alternates sides, last row open. Gives a long path.
   task automatic test_full_grid_serpentine();
      int r, c;
      for (r = 0; r < int'(MAX_ROWS); r++) begin
         for (c = 0; c < SNAKE_COLS; c++) begin
            if (r % 2 == 0 || r == int'(MAX_ROWS) - 1) begin
               maze_plan[r * SNAKE_COLS + c] = 1'b1;
            end else begin
               maze_plan[r * SNAKE_COLS + c] =
                  ((r / 2) % 2 == 0) ? (c == SNAKE_COLS - 1) : (c == 0);
            end
         end
      end
      set_grid(CSR_W'(255), CSR_W'(SNAKE_COLS));
      send_plan(int'(MAX_ROWS) * SNAKE_COLS);
   endtask

   // Mostly small grids; now and then one side out of range or at the limit
   // with the other kept thin so the maze stays short.
   task automatic pick_random_grid();
      logic [CSR_W-1:0] rows_v, cols_v, wild, thin;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         rows_v = CSR_W'($urandom_range(5, 1));
         cols_v = CSR_W'($urandom_range(5, 1));
      end else if (pick < 94) begin
         rows_v = CSR_W'($urandom_range(12, 1));
         cols_v = CSR_W'($urandom_range(12, 1));
      end else begin
         wild = ($urandom_range(2) == 0) ? CSR_W'(0) : CSR_W'($urandom_range(255, 128));
         thin = CSR_W'($urandom_range(2, 0));
         if ($urandom_range(1) == 0) begin
            rows_v = wild;
            cols_v = thin;
         end else begin
            rows_v = thin;
            cols_v = wild;
         end
      end
      set_grid(rows_v, cols_v);
   endtask

   // Random mazes, random wall density; half get a carved monotone path so
   // long reachable routes show up. About one maze in ten is cut short and
   // followed by a register write.
   task automatic test_random_mazes(input int idle_pct, input int stall_pct, input int budget);
      int sent, rows, cols, total, cut, open_pct, r, c, i;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      pick_random_grid();
      while (sent < budget) begin
         if ($urandom_range(2) == 0) pick_random_grid();
         rows  = dim_in_use(grid_rows_raw, MAX_ROWS);
         cols  = dim_in_use(grid_cols_raw, MAX_COLS);
         total = rows * cols;
         open_pct = $urandom_range(100, 45);
         for (i = 0; i < total; i++) maze_plan[i] = ($urandom_range(99) < open_pct);
         if ($urandom_range(1) == 0) begin
            r = 0;
            c = 0;
            maze_plan[0] = 1'b1;
            while (r != rows - 1 || c != cols - 1) begin
               if (r == rows - 1) c++;
               else if (c == cols - 1) r++;
               else if ($urandom_range(1) == 0) r++;
               else c++;
               maze_plan[r * cols + c] = 1'b1;
            end
         end
         cut = total;
         if (total > 1 && $urandom_range(9) == 0) cut = $urandom_range(total - 1, 1);
         send_plan(cut);
         sent += cut;
         if (cut < total) pick_random_grid();
      end
      drain_answers();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_single_cell();
      test_corner_walls();
      test_reload_after_write();
      test_clamped_strips();
      test_full_grid_serpentine();

      test_random_mazes(0, 0, 350);
      test_random_mazes(80, 0, 350);
      test_random_mazes(0, 80, 350);
      test_random_mazes(25, 25, 350);

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      drain_answers();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (answers_due.size() != 0) begin
         $error("%0d result words never arrived", answers_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hang guard, far above the slowest legal run.
   initial begin
      #40_000_000;
      $display("timeout: %0d result words outstanding", answers_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
